// ===== hdl/sgi_pkg.sv =====
// ----------------------------------------------------------------------------
// sgi_pkg
// Shared types for the 2d segment intersection block: the per-stage tag
// carried beside the datapath and the rounding flags of one coordinate lane.
// ----------------------------------------------------------------------------
package sgi_pkg;

  // valid and hit flag of one item in a pipeline stage
  typedef struct packed {
    logic valid;
    logic hit;
  } sgi_tag_t;

  // remainder compare against the divisor, used for round half away from zero
  typedef struct packed {
    logic gt;
    logic eq;
  } sgi_rnd_t;

endpackage

// ===== hdl/sgi_front.sv =====
// ----------------------------------------------------------------------------
// sgi_front
// Front part: takes one segment pair per cycle unless a full queue stalls it,
// forms the edge vectors and the three 2d cross products, then classifies
// the pair as hit or miss and hands the normalized operands to the queue.
// ----------------------------------------------------------------------------
module sgi_front #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [10*COORD_WIDTH-1:0]  in_data_i,
  output logic                       q_valid_o,
  input  logic                       q_ready_i,
  // hit, d, tn, e_z, e_y, e_x, p_z, p_y, p_x (msb first)
  output logic [10*COORD_WIDTH+5:0]  q_data_o
);
  import sgi_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int CW = 2*W + 2;   // signed cross product
  localparam int DW = 2*W + 1;   // magnitude of d and tn

  logic en;

  logic signed [W-1:0] a_sx, a_sy, a_sz, a_ex, a_ey, a_ez;
  logic signed [W-1:0] b_sx, b_sy, b_ex, b_ey;

  // stage 1: edge vectors
  logic                v1_q;
  logic signed [W-1:0] px1_q, py1_q, pz1_q;
  logic signed [W:0]   rx1_d, ry1_d, rz1_d, sx1_d, sy1_d, qx1_d, qy1_d;
  logic signed [W:0]   rx1_q, ry1_q, rz1_q, sx1_q, sy1_q, qx1_q, qy1_q;

  // stage 2: cross products
  logic                 v2_q;
  logic signed [W-1:0]  px2_q, py2_q, pz2_q;
  logic signed [W:0]    rx2_q, ry2_q, rz2_q;
  logic signed [CW-1:0] d2_d, tn2_d, un2_d;
  logic signed [CW-1:0] d2_q, tn2_q, un2_q;

  // stage 3: classification
  sgi_tag_t             t3_d, t3_q;
  logic signed [CW-1:0] dneg, tnneg, dsel, tnsel;
  logic                 dpos, dnz, in_pos, in_neg;
  logic [DW-1:0]        dabs3_q, tnabs3_q;
  logic signed [W-1:0]  px3_q, py3_q, pz3_q;
  logic signed [W:0]    ex3_q, ey3_q, ez3_q;

  // all stages move together when the last one can hand off
  assign en         = !t3_q.valid || q_ready_i;
  assign in_ready_o = en;

  // unpack the item
  assign a_sx = in_data_i[0*W +: W];
  assign a_sy = in_data_i[1*W +: W];
  assign a_sz = in_data_i[2*W +: W];
  assign a_ex = in_data_i[3*W +: W];
  assign a_ey = in_data_i[4*W +: W];
  assign a_ez = in_data_i[5*W +: W];
  assign b_sx = in_data_i[6*W +: W];
  assign b_sy = in_data_i[7*W +: W];
  assign b_ex = in_data_i[8*W +: W];
  assign b_ey = in_data_i[9*W +: W];

  // r = a_end - a_start, s = b_end - b_start, q = b_start - a_start
  assign rx1_d = (W+1)'(a_ex) - (W+1)'(a_sx);
  assign ry1_d = (W+1)'(a_ey) - (W+1)'(a_sy);
  assign rz1_d = (W+1)'(a_ez) - (W+1)'(a_sz);
  assign sx1_d = (W+1)'(b_ex) - (W+1)'(b_sx);
  assign sy1_d = (W+1)'(b_ey) - (W+1)'(b_sy);
  assign qx1_d = (W+1)'(b_sx) - (W+1)'(a_sx);
  assign qy1_d = (W+1)'(b_sy) - (W+1)'(a_sy);

  // d = r x s, tn = q x s, un = q x r
  assign d2_d  = rx1_q * sy1_q - ry1_q * sx1_q;
  assign tn2_d = qx1_q * sy1_q - qy1_q * sx1_q;
  assign un2_d = qx1_q * ry1_q - qy1_q * rx1_q;

  // both parameters in [0,1], tested on the sign of d without a divide
  always_comb begin
    dnz    = (d2_q != '0);
    dpos   = !d2_q[CW-1];
    in_pos = (tn2_q >= 0) && (tn2_q <= d2_q) && (un2_q >= 0) && (un2_q <= d2_q);
    in_neg = (tn2_q <= 0) && (tn2_q >= d2_q) && (un2_q <= 0) && (un2_q >= d2_q);
    t3_d.valid = v2_q;
    t3_d.hit   = dnz && (dpos ? in_pos : in_neg);
    dneg  = -d2_q;
    tnneg = -tn2_q;
    dsel  = dpos ? d2_q : dneg;
    tnsel = dpos ? tn2_q : tnneg;
  end

  // stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      t3_q <= '0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      t3_q <= t3_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (en) begin
      px1_q <= a_sx;
      py1_q <= a_sy;
      pz1_q <= a_sz;
      rx1_q <= rx1_d;
      ry1_q <= ry1_d;
      rz1_q <= rz1_d;
      sx1_q <= sx1_d;
      sy1_q <= sy1_d;
      qx1_q <= qx1_d;
      qy1_q <= qy1_d;

      px2_q <= px1_q;
      py2_q <= py1_q;
      pz2_q <= pz1_q;
      rx2_q <= rx1_q;
      ry2_q <= ry1_q;
      rz2_q <= rz1_q;
      d2_q  <= d2_d;
      tn2_q <= tn2_d;
      un2_q <= un2_d;

      px3_q    <= px2_q;
      py3_q    <= py2_q;
      pz3_q    <= pz2_q;
      ex3_q    <= rx2_q;
      ey3_q    <= ry2_q;
      ez3_q    <= rz2_q;
      dabs3_q  <= dsel[DW-1:0];
      tnabs3_q <= tnsel[DW-1:0];
    end
  end

  assign q_valid_o = t3_q.valid;
  assign q_data_o  = {t3_q.hit, dabs3_q, tnabs3_q, ez3_q, ey3_q, ex3_q, pz3_q, py3_q, px3_q};

endmodule

// ===== hdl/sgi_fifo.sv =====
// ----------------------------------------------------------------------------
// sgi_fifo
// Short first-word-fall-through queue between the front and back parts.
// ----------------------------------------------------------------------------
module sgi_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);
  import sgi_pkg::*;

  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CNTW-1:0]  cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CNTW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // pointer wrap and fill count
  always_comb begin
    wr_d = wr_q;
    rd_d = rd_q;
    if (push) wr_d = (wr_q == PW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
    if (pop)  rd_d = (rd_q == PW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
    unique case ({push, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_data_i;
  end

endmodule

// ===== hdl/sgi_lane.sv =====
// ----------------------------------------------------------------------------
// sgi_lane
// One coordinate of the back part: forms e*tn*2^F, divides it by d in a
// restoring divider pipelined one quotient bit per stage, and turns the
// floor quotient and remainder into the base value and rounding flags of
// p*2^F + e*tn*2^F/d.
// ----------------------------------------------------------------------------
module sgi_lane #(
  parameter int COORD_WIDTH = 16,
  parameter int FRAC_BITS   = 8
) (
  input  logic                                     clk_i,
  input  logic                                     en_i,
  input  logic signed [COORD_WIDTH-1:0]            p_i,
  input  logic signed [COORD_WIDTH:0]              e_i,
  input  logic        [2*COORD_WIDTH:0]            tn_i,
  input  logic        [2*COORD_WIDTH:0]            d_i,
  output logic signed [COORD_WIDTH+FRAC_BITS+1:0]  base_o,
  output sgi_pkg::sgi_rnd_t                        rnd_o
);
  import sgi_pkg::*;

  localparam int W   = COORD_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int H   = W + 1;         // split point of tn
  localparam int DW  = 2*W + 1;       // divisor and remainder
  localparam int QW  = W + F;         // quotient bits, one per stage
  localparam int MSW = 3*W + 2;       // signed e*tn
  localparam int AW  = 3*W + 1;       // magnitude of e*tn
  localparam int NW  = AW + F;        // dividend
  localparam int RW  = W + F + 2;     // base value

  // stage 1: two partial products over the halves of tn
  logic signed [2*W+2:0] pl_d, pl_q;
  logic signed [2*W+1:0] ph_d, ph_q;
  logic signed [W-1:0]   p1_q;
  logic [DW-1:0]         d1_q;

  // stage 2: recombined product
  logic signed [MSW-1:0] m_d, m_q;
  logic signed [W-1:0]   p2_q;
  logic [DW-1:0]         d2_q;

  // stage 3 and the divider steps
  logic signed [MSW-1:0] mabs;
  logic [NW-1:0]         n_c;
  logic [DW-1:0]         rem_q [QW+1];
  logic [QW-1:0]         nq_q  [QW+1];
  logic                  neg_q [QW+1];
  logic signed [W-1:0]   p_q   [QW+1];
  logic [DW-1:0]         d_q   [QW+1];
  logic [DW-1:0]         rem_d [QW];
  logic [QW-1:0]         nq_d  [QW];

  // floor correction and rounding
  logic signed [QW:0]    qe, f_d, f_q;
  logic [DW-1:0]         rr_d, rr_q, df_q;
  logic signed [W-1:0]   pf_q;
  logic                  rnz, negf;
  logic signed [RW-1:0]  base_d, base_q;
  logic [DW:0]           dbl;
  sgi_rnd_t              rnd_d, rnd_q;

  assign pl_d = e_i * $signed({1'b0, tn_i[H-1:0]});
  assign ph_d = e_i * $signed({1'b0, tn_i[DW-1:H]});
  assign m_d  = (MSW'(ph_q) <<< H) + MSW'(pl_q);

  // dividend magnitude, fraction bits appended
  always_comb begin
    mabs = m_q[MSW-1] ? -m_q : m_q;
    n_c  = NW'(mabs[AW-1:0]) << F;
  end

  // one restoring step per stage, quotient bits shift in as dividend bits leave
  always_comb begin
    logic [DW:0] ext;
    logic [DW:0] diff;
    logic        ge;
    for (int k = 0; k < QW; k++) begin
      ext      = {rem_q[k], nq_q[k][QW-1]};
      diff     = ext - {1'b0, d_q[k]};
      ge       = (ext >= {1'b0, d_q[k]});
      rem_d[k] = ge ? diff[DW-1:0] : ext[DW-1:0];
      nq_d[k]  = {nq_q[k][QW-2:0], ge};
    end
  end

  // signed floor quotient and nonnegative remainder
  always_comb begin
    qe   = $signed({1'b0, nq_q[QW]});
    rnz  = |rem_q[QW];
    negf = neg_q[QW];
    priority if (negf && rnz) begin
      f_d  = ~qe;
      rr_d = d_q[QW] - rem_q[QW];
    end else if (negf) begin
      f_d  = -qe;
      rr_d = rem_q[QW];
    end else begin
      f_d  = qe;
      rr_d = rem_q[QW];
    end
  end

  // base value and half-divisor compare
  always_comb begin
    base_d   = (RW'(pf_q) <<< F) + RW'(f_q);
    dbl      = {rr_q, 1'b0};
    rnd_d.gt = (dbl > {1'b0, df_q});
    rnd_d.eq = (dbl == {1'b0, df_q});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pl_q <= pl_d;
      ph_q <= ph_d;
      p1_q <= p_i;
      d1_q <= d_i;

      m_q  <= m_d;
      p2_q <= p1_q;
      d2_q <= d1_q;

      rem_q[0] <= n_c[NW-1:QW];
      nq_q[0]  <= n_c[QW-1:0];
      neg_q[0] <= m_q[MSW-1];
      p_q[0]   <= p2_q;
      d_q[0]   <= d2_q;
      for (int k = 0; k < QW; k++) begin
        rem_q[k+1] <= rem_d[k];
        nq_q[k+1]  <= nq_d[k];
        neg_q[k+1] <= neg_q[k];
        p_q[k+1]   <= p_q[k];
        d_q[k+1]   <= d_q[k];
      end

      f_q  <= f_d;
      rr_q <= rr_d;
      pf_q <= p_q[QW];
      df_q <= d_q[QW];

      base_q <= base_d;
      rnd_q  <= rnd_d;
    end
  end

  assign base_o = base_q;
  assign rnd_o  = rnd_q;

endmodule

// ===== hdl/sgi_back.sv =====
// ----------------------------------------------------------------------------
// sgi_back
// Back part: pops classified items from the queue, runs the three coordinate
// lanes in lockstep with a tag pipeline, rounds, and holds the result in the
// output register.
// ----------------------------------------------------------------------------
module sgi_back #(
  parameter int COORD_WIDTH = 16,
  parameter int FRAC_BITS   = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_valid_i,
  output logic                      q_ready_o,
  input  logic [10*COORD_WIDTH+5:0] q_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  // cross_x, cross_y, cross_z from the lowest bit up, zero filled
  output logic [((3*(COORD_WIDTH+FRAC_BITS)+7)/8)*8-1:0] out_data_o,
  output logic                      out_hit_o
);
  import sgi_pkg::*;

  localparam int W   = COORD_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int OW  = W + F;
  localparam int RW  = W + F + 2;
  localparam int DW  = 2*W + 1;
  localparam int LAT = W + F + 5;   // register stages of one lane
  localparam int OTW = ((3*OW + 7)/8)*8;

  logic                en;
  logic                hit;
  logic [DW-1:0]       d, tn;
  logic signed [W:0]   ex, ey, ez;
  logic signed [W-1:0] px, py, pz;

  sgi_tag_t             tag_q [LAT];
  logic signed [RW-1:0] base_c [3];
  sgi_rnd_t             rnd_c  [3];
  logic [OW-1:0]        res_d  [3];
  logic [OW-1:0]        res_q  [3];
  logic                 out_valid_q, hit_q;

  assign {hit, d, tn, ez, ey, ex, pz, py, px} = q_data_i;

  // the pipeline advances whenever the output register is free or drained
  assign en        = !out_valid_q || out_ready_i;
  assign q_ready_o = en;

  sgi_lane #(.COORD_WIDTH(W), .FRAC_BITS(F)) u_lane_x (
    .clk_i (clk_i), .en_i (en), .p_i (px), .e_i (ex), .tn_i (tn), .d_i (d),
    .base_o (base_c[0]), .rnd_o (rnd_c[0])
  );

  sgi_lane #(.COORD_WIDTH(W), .FRAC_BITS(F)) u_lane_y (
    .clk_i (clk_i), .en_i (en), .p_i (py), .e_i (ey), .tn_i (tn), .d_i (d),
    .base_o (base_c[1]), .rnd_o (rnd_c[1])
  );

  sgi_lane #(.COORD_WIDTH(W), .FRAC_BITS(F)) u_lane_z (
    .clk_i (clk_i), .en_i (en), .p_i (pz), .e_i (ez), .tn_i (tn), .d_i (d),
    .base_o (base_c[2]), .rnd_o (rnd_c[2])
  );

  // round half away from zero, zero result on a miss
  always_comb begin
    logic                 inc;
    logic signed [RW-1:0] sum;
    for (int k = 0; k < 3; k++) begin
      inc      = rnd_c[k].gt || (rnd_c[k].eq && !base_c[k][RW-1]);
      sum      = base_c[k] + {{(RW-1){1'b0}}, inc};
      res_d[k] = tag_q[LAT-1].hit ? sum[OW-1:0] : '0;
    end
  end

  // tag pipeline and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LAT; k++) tag_q[k] <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      tag_q[0].valid <= q_valid_i;
      tag_q[0].hit   <= hit;
      for (int k = 1; k < LAT; k++) tag_q[k] <= tag_q[k-1];
      out_valid_q <= tag_q[LAT-1].valid;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q <= tag_q[LAT-1].hit;
      for (int k = 0; k < 3; k++) res_q[k] <= res_d[k];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_hit_o   = hit_q;
  assign out_data_o  = OTW'({res_q[2], res_q[1], res_q[0]});

endmodule

// ===== hdl/segment_intersect_2d.sv =====
// ----------------------------------------------------------------------------
// segment_intersect_2d
// 2d segment intersection with z interpolated along the first segment,
// exact integer tests and fixed-point results rounded to nearest.
// ----------------------------------------------------------------------------
// The block takes one segment pair per clock while s_axis_tready is high and
// returns one result per pair, in order. The divider in each coordinate lane
// resolves one quotient bit per pipeline stage. The front part (edge vectors,
// cross products, hit test) and the back part (multiply, divide, round) are
// separated by a four-item queue, so a stall on the result side first fills
// the queue before the input side stops. Parallel or degenerate pairs and
// misses return hit = 0 with all coordinates zero; endpoints touching count
// as a hit.
// ----------------------------------------------------------------------------
module segment_intersect_2d #(
  parameter int COORD_WIDTH = 16,
  parameter int FRAC_BITS   = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // a_start_x, a_start_y, a_start_z, a_end_x, a_end_y, a_end_z,
  // b_start_x, b_start_y, b_end_x, b_end_y from the lowest bit up
  input  logic [((10*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // cross_x, cross_y, cross_z from the lowest bit up
  output logic [((3*(COORD_WIDTH+FRAC_BITS)+7)/8)*8-1:0] m_axis_tdata,
  // hit
  output logic m_axis_tuser
);
  import sgi_pkg::*;

  localparam int W     = COORD_WIDTH;
  localparam int EW    = 10*W + 6;
  localparam int QDEPTH = 4;

  logic          push_valid, push_ready, pop_valid, pop_ready;
  logic [EW-1:0] push_data, pop_data;

  sgi_front #(.COORD_WIDTH(W)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (s_axis_tdata[10*W-1:0]),
    .q_valid_o  (push_valid),
    .q_ready_i  (push_ready),
    .q_data_o   (push_data)
  );

  sgi_fifo #(.WIDTH(EW), .DEPTH(QDEPTH)) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  sgi_back #(.COORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (pop_valid),
    .q_ready_o   (pop_ready),
    .q_data_i    (pop_data),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_hit_o   (m_axis_tuser)
  );

`ifndef SYNTHESIS
  // a miss carries all-zero coordinates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("miss result with nonzero coordinates");

  // the input side only stalls when the queue is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> push_valid && !push_ready)
    else $error("front stalled without a full queue");

  // the back part only pops when its output register can move
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_valid && pop_ready |-> !m_axis_tvalid || m_axis_tready)
    else $error("queue popped while the result register is held");
`endif

endmodule

// ===== test/segment_intersect_2d_test.sv =====
// ----------------------------------------------------------------------------
// segment_intersect_2d_test
// Streams segment pairs into the 2d intersection block and checks each result
// item against a fixed-point model of the hit test and the rounded crossing
// point. A short table of hand-picked pairs comes first, covering parallel,
// degenerate, touching and coordinate extreme cases. Random pairs with random
// gaps on both stream sides follow.
// ----------------------------------------------------------------------------
module segment_intersect_2d_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_W    = 16;
  localparam int FRAC_W     = 8;
  localparam int OUT_W      = COORD_W + FRAC_W;
  localparam int IN_BITS    = ((10*COORD_W+7)/8)*8;
  localparam int OUT_BITS   = ((3*OUT_W+7)/8)*8;
  localparam int DIR_ROWS   = 23;
  localparam int RAND_ITEMS = 1330;
  localparam int STALL_MAX  = 17;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYC  = 60;
  // marks a table row whose result comes from the crossing model
  localparam int PREDICTED  = -1;

  // one segment pair as it enters the block
  typedef struct {
    shortint as_x, as_y, as_z;
    shortint ae_x, ae_y, ae_z;
    shortint bs_x, bs_y;
    shortint be_x, be_y;
  } seg_pair_t;

  // one result item
  typedef struct packed {
    logic             hit;
    logic [OUT_W-1:0] cross_x;
    logic [OUT_W-1:0] cross_y;
    logic [OUT_W-1:0] cross_z;
  } crossing_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [IN_BITS-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OUT_BITS-1:0] m_axis_tdata;
  logic                m_axis_tuser;

  crossing_t   pending_crossings[$];
  int unsigned err_count;
  int unsigned results_seen;
  int unsigned idle_cycles;
  bit          stimulus_done;

  // directed pairs: a start xyz, a end xyz, b start xy, b end xy
  int stim_tbl [DIR_ROWS][10] = '{
    '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 10, 0, 0, 0, 5, 10, 5},
    '{0, 0, 0, 10, 0, 0, 5, 0, 15, 0},
    '{0, 0, 0, 10, 10, 10, 3, 3, 3, 3},
    '{0, 0, 0, 10, 10, 100, 0, 10, 10, 0},
    '{0, 0, 0, 10, 10, 100, 10, 0, 0, 10},
    '{0, 0, 7, 10, 0, 9, 0, -5, 0, 5},
    '{0, 0, 7, 10, 0, 9, 10, -5, 10, 5},
    '{0, 0, 0, 10, 0, 20, 5, 0, 5, 7},
    '{0, 0, 0, 10, 0, 20, 5, -7, 5, 0},
    '{0, 0, 0, 4, 4, 4, 4, 4, 8, 0},
    '{0, 0, 0, 10, 0, 0, 11, -5, 11, 5},
    '{0, 0, 0, 10, 0, 0, 5, 1, 5, 7},
    '{0, 0, 0, 1, 512, -1, -5, 1, 5, 1},
    '{0, 0, 0, -1, 512, 1, -5, 1, 5, 1},
    '{-32768, -32768, -32768, 32767, 32767, 32767, -32768, 32767, 32767, -32768},
    '{-32768, -32768, -32768, 32767, 32767, 32767, -32768, -32768, -32768, 32767},
    '{-32768, -32768, -32768, 32767, 32767, 32767, 32767, 32767, 32767, -32768},
    '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768},
    '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767},
    '{-32768, 32767, 0, 32767, 32767, 0, -32768, -32768, 32767, -32768},
    '{0, 0, -32768, 2, 0, 32767, 1, -1, 1, 1},
    '{0, 0, 0, 3, 3, 3, 0, 1, 1, 0}
  };

  // typed results: hit, cross_x, cross_y, cross_z
  int want_tbl [DIR_ROWS][4] = '{
    '{0, 0, 0, 0},
    '{0, 0, 0, 0},
    '{0, 0, 0, 0},
    '{0, 0, 0, 0},
    '{PREDICTED, 0, 0, 0},
    '{PREDICTED, 0, 0, 0},
    '{PREDICTED, 0, 0, 0},
    '{PREDICTED, 0, 0, 0},
    '{PREDICTED, 0, 0, 0},
    '{PREDICTED, 0, 0, 0},
    '{PREDICTED, 0, 0, 0},
    '{0, 0, 0, 0},
    '{0, 0, 0, 0},
    '{PREDICTED, 0, 0, 0},
    '{PREDICTED, 0, 0, 0},
    '{PREDICTED, 0, 0, 0},
    '{1, -8388608, -8388608, -8388608},
    '{1, 8388352, 8388352, 8388352},
    '{0, 0, 0, 0},
    '{0, 0, 0, 0},
    '{0, 0, 0, 0},
    '{PREDICTED, 0, 0, 0},
    '{PREDICTED, 0, 0, 0}
  };

  segment_intersect_2d #(
    .COORD_WIDTH(COORD_W),
    .FRAC_BITS  (FRAC_W)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // one coordinate of the crossing point, scaled and rounded half away from zero
  function automatic logic [OUT_W-1:0] round_coord(longint p, longint e, longint tn,
                                                   longint den);
    longint num;
    longint quo;
    bit     neg;
    num = (p * den + e * tn) * (longint'(1) << FRAC_W);
    neg = num < 0;
    if (neg) begin
      num = -num;
    end
    quo = (2 * num + den) / (2 * den);
    if (neg) begin
      quo = -quo;
    end
    return quo[OUT_W-1:0];
  endfunction

  // exact hit test and crossing point of one pair
  function automatic crossing_t predict_crossing(seg_pair_t sp);
    crossing_t res;
    longint    px, py, pz, rx, ry, rz, qx, qy, sx, sy;
    longint    den, tn, un;
    px  = sp.as_x;
    py  = sp.as_y;
    pz  = sp.as_z;
    rx  = longint'(sp.ae_x) - px;
    ry  = longint'(sp.ae_y) - py;
    rz  = longint'(sp.ae_z) - pz;
    sx  = longint'(sp.be_x) - longint'(sp.bs_x);
    sy  = longint'(sp.be_y) - longint'(sp.bs_y);
    qx  = longint'(sp.bs_x) - px;
    qy  = longint'(sp.bs_y) - py;
    den = rx * sy - ry * sx;
    tn  = qx * sy - qy * sx;
    un  = qx * ry - qy * rx;
    res = '0;
    // parallel or degenerate: no hit
    if (den == 0) begin
      return res;
    end
    if (den < 0) begin
      den = -den;
      tn  = -tn;
      un  = -un;
    end
    if (tn < 0 || tn > den || un < 0 || un > den) begin
      return res;
    end
    res.hit     = 1'b1;
    res.cross_x = round_coord(px, rx, tn, den);
    res.cross_y = round_coord(py, ry, tn, den);
    res.cross_z = round_coord(pz, rz, tn, den);
    return res;
  endfunction

  function automatic shortint coord_in(int lo, int hi);
    return shortint'(int'($urandom_range(0, hi - lo)) + lo);
  endfunction

  // random pair, biased toward touching, parallel and degenerate geometry
  function automatic seg_pair_t random_pair();
    seg_pair_t sp;
    int        span;
    shortint   dx, dy;
    int unsigned mode;
    mode = $urandom_range(0, 9);
    span = (mode inside {4, 5}) ? 8 : (mode inside {7, 8}) ? 300 : 32768;
    sp.as_x = coord_in(-span, span - 1);
    sp.as_y = coord_in(-span, span - 1);
    sp.as_z = shortint'($urandom());
    sp.ae_x = coord_in(-span, span - 1);
    sp.ae_y = coord_in(-span, span - 1);
    sp.ae_z = shortint'($urandom());
    sp.bs_x = coord_in(-span, span - 1);
    sp.bs_y = coord_in(-span, span - 1);
    sp.be_x = coord_in(-span, span - 1);
    sp.be_y = coord_in(-span, span - 1);
    case (mode)
      // b shares an endpoint with a
      6: begin
        if ($urandom_range(0, 1)) begin
          sp.bs_x = sp.as_x;
          sp.bs_y = sp.as_y;
        end else begin
          sp.be_x = sp.ae_x;
          sp.be_y = sp.ae_y;
        end
      end
      // b is a shifted copy of a
      7: begin
        dx = coord_in(-50, 50);
        dy = coord_in(-50, 50);
        sp.bs_x = sp.as_x + dx;
        sp.bs_y = sp.as_y + dy;
        sp.be_x = sp.ae_x + dx;
        sp.be_y = sp.ae_y + dy;
      end
      // one segment collapsed to a point
      9: begin
        if ($urandom_range(0, 1)) begin
          sp.ae_x = sp.as_x;
          sp.ae_y = sp.as_y;
        end else begin
          sp.be_x = sp.bs_x;
          sp.be_y = sp.bs_y;
        end
      end
      default: begin
      end
    endcase
    return sp;
  endfunction

  // wait per item, with occasional stretches of back-to-back transfers
  function automatic int draw_gap(ref int burst_left);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) begin
      burst_left = $urandom_range(10, 60);
    end
    return $urandom_range(0, STALL_MAX);
  endfunction

  task automatic report_mismatch(string field, logic [OUT_W-1:0] got,
                                 logic [OUT_W-1:0] want);
    $display("mismatch at result %0d: %s got 0x%06h want 0x%06h",
             results_seen, field, got, want);
    err_count++;
  endtask

  // drive one pair from a falling edge and hold it until accepted
  task automatic push_pair(seg_pair_t sp, crossing_t want, ref int burst_left);
    int gap;
    gap = draw_gap(burst_left);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {sp.be_y, sp.be_x, sp.bs_y, sp.bs_x,
                      sp.ae_z, sp.ae_y, sp.ae_x, sp.as_z, sp.as_y, sp.as_x};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_crossings.push_back(want);
    @(negedge clk_i);
  endtask

  // reset and stimulus
  initial begin
    seg_pair_t sp;
    crossing_t want;
    int        burst_left;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    err_count     = 0;
    results_seen  = 0;
    stimulus_done = 1'b0;
    burst_left    = 0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      sp.as_x = shortint'(stim_tbl[i][0]);
      sp.as_y = shortint'(stim_tbl[i][1]);
      sp.as_z = shortint'(stim_tbl[i][2]);
      sp.ae_x = shortint'(stim_tbl[i][3]);
      sp.ae_y = shortint'(stim_tbl[i][4]);
      sp.ae_z = shortint'(stim_tbl[i][5]);
      sp.bs_x = shortint'(stim_tbl[i][6]);
      sp.bs_y = shortint'(stim_tbl[i][7]);
      sp.be_x = shortint'(stim_tbl[i][8]);
      sp.be_y = shortint'(stim_tbl[i][9]);
      if (want_tbl[i][0] == PREDICTED) begin
        want = predict_crossing(sp);
      end else begin
        want.hit     = want_tbl[i][0][0];
        want.cross_x = want_tbl[i][1][OUT_W-1:0];
        want.cross_y = want_tbl[i][2][OUT_W-1:0];
        want.cross_z = want_tbl[i][3][OUT_W-1:0];
      end
      push_pair(sp, want, burst_left);
    end

    // random pairs
    for (int i = 0; i < RAND_ITEMS; i++) begin
      sp = random_pair();
      push_pair(sp, predict_crossing(sp), burst_left);
    end
    s_axis_tvalid <= 1'b0;
    stimulus_done = 1'b1;
  end

  // result side: random stalls, field by field compare
  initial begin
    crossing_t got;
    crossing_t want;
    int        stall;
    int        burst_left;
    m_axis_tready = 1'b0;
    burst_left    = 0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = draw_gap(burst_left);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      got.hit     = m_axis_tuser;
      got.cross_x = m_axis_tdata[OUT_W-1:0];
      got.cross_y = m_axis_tdata[2*OUT_W-1:OUT_W];
      got.cross_z = m_axis_tdata[3*OUT_W-1:2*OUT_W];
      if (pending_crossings.size() == 0) begin
        $display("result %0d arrived with nothing outstanding", results_seen);
        err_count++;
      end else begin
        want = pending_crossings.pop_front();
        if (got.hit !== want.hit) begin
          report_mismatch("hit", OUT_W'(got.hit), OUT_W'(want.hit));
        end
        if (got.cross_x !== want.cross_x) begin
          report_mismatch("cross_x", got.cross_x, want.cross_x);
        end
        if (got.cross_y !== want.cross_y) begin
          report_mismatch("cross_y", got.cross_y, want.cross_y);
        end
        if (got.cross_z !== want.cross_z) begin
          report_mismatch("cross_z", got.cross_z, want.cross_z);
        end
      end
      results_seen++;
      @(negedge clk_i);
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("stream stalled for %0d cycles", idle_cycles);
        $display("segment_intersect_2d_test: errors");
        $finish;
      end
    end else begin
      idle_cycles <= 0;
    end
  end

  // end of run: drain, settle, verdict
  initial begin
    wait (stimulus_done);
    while (pending_crossings.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (pending_crossings.size() != 0) begin
      $display("%0d results never arrived", pending_crossings.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("segment_intersect_2d_test: clean");
    end else begin
      $display("segment_intersect_2d_test: errors");
    end
    $finish;
  end

endmodule
